@@ sv/assert_macros.svh @@
// Assertion helpers used by the port-level checker of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define STCE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define STCE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/stce_pkg.sv @@
// ---------------------------------------------------------------------------
// stce_pkg
// Types and constants of the scrambled tail-biting K=7 convolutional encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package stce_pkg;

   // Block geometry
   localparam int MAX_BLOCK_BITS = 262144;
   localparam int GROUP_BITS     = 8;
   localparam int GROUP_W        = $clog2(MAX_BLOCK_BITS / GROUP_BITS);
   localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(MAX_BLOCK_BITS / GROUP_BITS - 1);

   // Encoder lanes: eight for a group, six for the tail
   localparam int NUM_LANES = 8;
   localparam int TAIL_BITS = 6;

   // Scrambler
   localparam int         SCR_W    = 11;
   localparam logic [10:0] SCR_INIT = 11'h3ff;

   // Generator polynomials (octal)
   localparam logic [6:0] POLY_A = 7'o133;
   localparam logic [6:0] POLY_B = 7'o171;
   localparam logic [6:0] POLY_C = 7'o165;

   // Field widths
   localparam int CODED_W = 20;
   localparam int COUNT_W = 5;
   localparam int POS_W   = 20;
   localparam int LCNT_W  = 4;

   // Rate codes
   localparam logic RATE_2_5 = 1'b0;
   localparam logic RATE_1_2 = 1'b1;

   // Parities of one lane
   typedef struct packed {
      logic a;
      logic b;
      logic c;
   } lane_par_type;

   typedef lane_par_type [NUM_LANES-1:0] lane_vec_type;

   // One result transaction
   typedef struct packed {
      logic [CODED_W-1:0] coded_bits;
      logic [COUNT_W-1:0] coded_count;
      logic [POS_W-1:0]   out_position;
      logic               last_result;
   } rsp_item_type;

endpackage

@@ sv/stce_lane.sv @@
// ---------------------------------------------------------------------------
// stce_lane
// One encoder lane: the three generator parities of a 7-bit window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stce_lane
   import stce_pkg::*;
(
   input  logic [6:0]   window,   // bit 6 is the newest bit
   output lane_par_type par
);

   // XOR trees of the masked window
   assign par.a = ^(window & POLY_A);
   assign par.b = ^(window & POLY_B);
   assign par.c = ^(window & POLY_C);

endmodule

@@ sv/stce_merge.sv @@
// ---------------------------------------------------------------------------
// stce_merge
// Packs the parities of the first n lanes into one coded word, in block
// order, and gives the number of coded bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stce_merge
   import stce_pkg::*;
(
   input  lane_vec_type        lanes,       // lane 0 sits on an even bit
   input  logic [LCNT_W-1:0]   num_lanes,
   input  logic                rate_mode,
   output logic [CODED_W-1:0]  coded_bits,
   output logic [COUNT_W-1:0]  coded_count
);

   // Place each lane at its fixed slot; lanes past num_lanes give zeros
   always_comb begin
      coded_bits = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (LCNT_W'(k) < num_lanes) begin
            if (rate_mode == RATE_1_2) begin
               coded_bits[2*k]   = lanes[k].a;
               coded_bits[2*k+1] = lanes[k].c;
            end else begin
               coded_bits[5*(k/2)+3*(k%2)]   = lanes[k].a;
               coded_bits[5*(k/2)+3*(k%2)+1] = lanes[k].b;
               if ((k % 2) == 0) begin
                  coded_bits[5*(k/2)+2] = lanes[k].c;
               end
            end
         end
      end
   end

   // Two bits per lane at rate 1/2, five per lane pair at rate 2/5
   always_comb begin
      if (rate_mode == RATE_1_2) begin
         coded_count = COUNT_W'({num_lanes, 1'b0});
      end else begin
         coded_count = COUNT_W'({num_lanes[LCNT_W-1:1], 2'b00})
                     + COUNT_W'(num_lanes[LCNT_W-1:1])
                     + (num_lanes[0] ? COUNT_W'(3) : COUNT_W'(0));
      end
   end

endmodule

@@ sv/stce_rsp_queue.sv @@
// ---------------------------------------------------------------------------
// stce_rsp_queue
// Four-entry queue; takes up to two results a cycle, hands out one while
// out_ready is high. Ready for a new group whenever two entries are free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stce_rsp_queue
   import stce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push0,
   input  rsp_item_type item0,
   input  logic         push1,     // only together with push0
   input  rsp_item_type item1,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= (PTR_W+1)'(DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push0) + PTR_W'(push1);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W+1)'(push0) + (PTR_W+1)'(push1) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= item0;
      end
      if (push1) begin
         entry_ff[wr_next] <= item1;
      end
   end

endmodule

@@ sv/scramble_tailbiting_conv_encoder_top.sv @@
// ---------------------------------------------------------------------------
// scramble_tailbiting_conv_encoder_top
// Scrambled tail-biting K=7 convolutional encoder, rate 2/5 or 1/2, eight
// bits per transaction through eight parallel encoder lanes.
// ---------------------------------------------------------------------------
//  channel | dir | transaction
//  req_    | in  | tdata[7:0] input_bits, tlast last_of_block
//  rsp_    | out | tdata coded_bits/coded_count/out_position, tlast last_result
//  csr_    | in  | wr_en/wr_data rate_mode (0: rate 2/5, 1: rate 1/2)
//
//  One group of eight bits is taken every cycle while req_tready is high;
//  scrambling, the eight lanes and the merge are combinational ahead of a
//  four-entry result queue. The last group of a block gives two results,
//  drained one per cycle while rsp_tready is high; G groups give G+1 results.
//  req_tready drops while fewer than two queue entries are free.
//  reset is synchronous and clears rate_mode, the block state and the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scramble_tailbiting_conv_encoder_top
   import stce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input groups
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] input_bits
   input  logic        req_tlast,   // last_of_block
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [19:0] coded_bits, [24:20] coded_count,
                                    // [44:25] out_position, [47:45] zero
   output logic        rsp_tlast,   // last_result
   // Configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // rate_mode
);

   logic               rate_ff;
   logic [SCR_W-1:0]   scr_ff, scr_in;
   logic [5:0]         recent_ff, recent_in;
   logic [5:0]         head_ff, head_in;
   logic [GROUP_W-1:0] group_ff, group_in;

   logic               accept;
   logic               first_group;
   logic               close_block;
   logic [13:0]        seq;
   logic [11:0]        tail_seq;
   logic [5:0]         head_sel;
   lane_vec_type       body_par;
   lane_par_type [TAIL_BITS-1:0] tail_par;
   lane_vec_type       body_lanes;
   lane_vec_type       tail_lanes;
   logic [LCNT_W-1:0]  body_num;
   logic [CODED_W-1:0] body_code, tail_code;
   logic [COUNT_W-1:0] body_cnt, tail_cnt;
   logic [POS_W-1:0]   body_pos;
   rsp_item_type       body_item, tail_item, out_item;
   logic               room;

   assign req_tready  = room;
   assign accept      = req_tvalid && req_tready;
   assign first_group = (group_ff == '0);
   assign close_block = req_tlast || (group_ff == LAST_GROUP);

   // Rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_2_5;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   // Scrambler: eight LFSR steps, input bit 7 first
   always_comb begin
      logic [SCR_W-1:0] lfsr;
      logic             nb;
      lfsr = scr_ff;
      seq  = {8'h00, recent_ff};
      for (int i = 0; i < 8; i++) begin
         nb          = lfsr[9] ^ lfsr[0];
         seq[6+i]    = req_tdata[7-i] ^ nb;
         lfsr        = {nb, lfsr[SCR_W-1:1]};
      end
      scr_in = lfsr;
   end

   // Tail window: last six bits wrapped onto the first six of the block
   assign recent_in = seq[13:8];
   assign head_sel  = first_group ? seq[11:6] : head_ff;
   assign tail_seq  = {head_sel, recent_in};

   // Encoder lanes
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_body
      stce_lane u_lane (
         .window (seq[i+6:i]),
         .par    (body_par[i])
      );
   end

   for (genvar i = 0; i < TAIL_BITS; i++) begin : g_tail
      stce_lane u_lane (
         .window (tail_seq[i+6:i]),
         .par    (tail_par[i])
      );
   end

   // The first group only yields bits six and seven
   always_comb begin
      body_lanes = body_par;
      body_num   = LCNT_W'(NUM_LANES);
      if (first_group) begin
         body_lanes    = '0;
         body_lanes[0] = body_par[6];
         body_lanes[1] = body_par[7];
         body_num      = LCNT_W'(2);
      end
      tail_lanes = '0;
      tail_lanes[TAIL_BITS-1:0] = tail_par[TAIL_BITS-1:0];
   end

   stce_merge u_body_merge (
      .lanes       (body_lanes),
      .num_lanes   (body_num),
      .rate_mode   (rate_ff),
      .coded_bits  (body_code),
      .coded_count (body_cnt)
   );

   stce_merge u_tail_merge (
      .lanes       (tail_lanes),
      .num_lanes   (LCNT_W'(TAIL_BITS)),
      .rate_mode   (rate_ff),
      .coded_bits  (tail_code),
      .coded_count (tail_cnt)
   );

   // Coded position: 16 per group at rate 1/2, 20 at rate 2/5
   always_comb begin
      if (first_group) begin
         body_pos = (rate_ff == RATE_1_2) ? POS_W'(12) : POS_W'(15);
      end else if (rate_ff == RATE_1_2) begin
         body_pos = POS_W'({group_ff, 4'b0000});
      end else begin
         body_pos = POS_W'({group_ff, 4'b0000}) + POS_W'({group_ff, 2'b00});
      end
   end

   always_comb begin
      body_item.coded_bits   = body_code;
      body_item.coded_count  = body_cnt;
      body_item.out_position = body_pos;
      body_item.last_result  = 1'b0;
      tail_item.coded_bits   = tail_code;
      tail_item.coded_count  = tail_cnt;
      tail_item.out_position = '0;
      tail_item.last_result  = 1'b1;
   end

   // Block state
   always_comb begin
      head_in  = first_group ? seq[11:6] : head_ff;
      group_in = group_ff + GROUP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_ff    <= SCR_INIT;
         recent_ff <= '0;
         head_ff   <= '0;
         group_ff  <= '0;
      end else if (accept) begin
         if (close_block) begin
            scr_ff    <= SCR_INIT;
            recent_ff <= '0;
            head_ff   <= '0;
            group_ff  <= '0;
         end else begin
            scr_ff    <= scr_in;
            recent_ff <= recent_in;
            head_ff   <= head_in;
            group_ff  <= group_in;
         end
      end
   end

   // Result queue
   stce_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (accept),
      .item0     (body_item),
      .push1     (accept && close_block),
      .item1     (tail_item),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {3'b000, out_item.out_position, out_item.coded_count,
                       out_item.coded_bits};
   assign rsp_tlast = out_item.last_result;

endmodule

@@ sv/stce_checker.sv @@
// ---------------------------------------------------------------------------
// stce_checker
// Port-level checks of the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stce_assert_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A held result stays offered
   `STCE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")

   // Reset empties the result queue
   `STCE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result offered after reset")

   // The tail result starts the coded block and has 15 or 12 bits
   `STCE_ASSERT(a_tail_shape, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tdata[44:25] == 20'd0 && (rsp_tdata[24:20] == 5'd15 || rsp_tdata[24:20] == 5'd12), "bad tail result")

   // Coded bits above the count are zero for the short head result at rate 1/2
   `STCE_ASSERT(a_short_zero, clock, reset, rsp_tvalid && !rsp_tlast && rsp_tdata[24:20] == 5'd4 |-> rsp_tdata[19:4] == 16'd0, "stray coded bits")

   // Accepting a group leaves a result to offer next cycle
   `STCE_ASSERT(a_accept_result, clock, reset, req_tvalid && req_tready |=> rsp_tvalid, "group produced no result")

endmodule

bind scramble_tailbiting_conv_encoder_top stce_assert_checker u_stce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ sim/stce_checker.sv @@
// ---------------------------------------------------------------------------
// stce_checker
// Watches the group, result and register channels of the scrambled
// tail-biting encoder, predicts every result transaction from the accepted
// groups and compares the block's results against them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stce_checker
   import stce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] input_bits
   input  logic        req_tlast,   // last_of_block
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [19:0] coded_bits, [24:20] coded_count,
                                    // [44:25] out_position, [47:45] zero
   input  logic        rsp_tlast,   // last_result
   input  logic        csr_wr_en,
   input  logic        csr_wr_data, // rate_mode
   output int          fail_count,
   output int          outstanding,
   output int          results_checked
);

   localparam int COUNT_LSB = CODED_W;
   localparam int POS_LSB   = COUNT_LSB + COUNT_W;
   localparam int PAD_LSB   = POS_LSB + POS_W;

   // Encoder state as the block should hold it
   logic               rate_sel;
   logic [SCR_W-1:0]   scr_state;
   logic [5:0]         recent_bits;
   logic [5:0]         head_bits;
   logic [GROUP_W-1:0] group_idx;

   rsp_item_type coded_q[$];
   int errors    = 0;
   int n_checked = 0;

   function automatic void clear_block_state();
      scr_state   = SCR_INIT;
      recent_bits = '0;
      head_bits   = '0;
      group_idx   = '0;
   endfunction

   // Parities of a run of bits; seq bit i+6 is the newest bit of window i
   function automatic logic [CODED_W-1:0] conv_run(input logic [13:0] seq,
                                                  input int first, input int nbits,
                                                  input logic half,
                                                  output logic [COUNT_W-1:0] n_out);
      logic [CODED_W-1:0] acc;
      logic [6:0]         w;
      int                 n;
      int                 i;
      acc = '0;
      n   = 0;
      for (i = first; i < first + nbits; i++) begin
         w = seq[i +: 7];
         acc[n] = ^(w & POLY_A);
         n++;
         if (half == RATE_1_2) begin
            acc[n] = ^(w & POLY_C);
            n++;
         end else begin
            acc[n] = ^(w & POLY_B);
            n++;
            // even bits carry the third parity in rate 2/5
            if (i % 2 == 0) begin
               acc[n] = ^(w & POLY_C);
               n++;
            end
         end
      end
      n_out = COUNT_W'(n);
      return acc;
   endfunction

   // Start of bit p in the block's coded stream
   function automatic logic [POS_W-1:0] coded_pos(input int p, input logic half);
      return POS_W'((half == RATE_1_2) ? p * 2 : (p / 2) * 5 + (p % 2) * 3);
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("[%0t] MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               $time, n_checked, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : monitor
      logic [13:0]        seq;
      logic [SCR_W-1:0]   lfsr;
      logic               nb;
      logic               closes;
      logic [COUNT_W-1:0] cnt;
      rsp_item_type       item;
      rsp_item_type       want;
      int                 i;
      if (reset) begin
         clear_block_state();
         rate_sel = RATE_2_5;
         coded_q.delete();
      end else begin
         // Result transaction: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (coded_q.size() == 0) begin
               report_mismatch("with nothing expected", rsp_tdata, 0);
            end else begin
               want = coded_q.pop_front();
               if (rsp_tdata[CODED_W-1:0] !== want.coded_bits)
                  report_mismatch("coded_bits", rsp_tdata[CODED_W-1:0], want.coded_bits);
               if (rsp_tdata[COUNT_LSB +: COUNT_W] !== want.coded_count)
                  report_mismatch("coded_count", rsp_tdata[COUNT_LSB +: COUNT_W],
                                  want.coded_count);
               if (rsp_tdata[POS_LSB +: POS_W] !== want.out_position)
                  report_mismatch("out_position", rsp_tdata[POS_LSB +: POS_W],
                                  want.out_position);
               if (rsp_tdata[47:PAD_LSB] !== '0)
                  report_mismatch("pad bits", rsp_tdata[47:PAD_LSB], 0);
               if (rsp_tlast !== want.last_result)
                  report_mismatch("last_result", rsp_tlast, want.last_result);
            end
            n_checked++;
         end

         // Group transaction: scramble, encode, queue the results
         if (req_tvalid && req_tready) begin
            seq  = {8'b0, recent_bits};
            lfsr = scr_state;
            for (i = 0; i < GROUP_BITS; i++) begin
               nb         = lfsr[9] ^ lfsr[0];
               seq[6 + i] = req_tdata[7 - i] ^ nb;
               lfsr       = {nb, lfsr[SCR_W-1:1]};
            end
            // the length limit closes a block even without tlast
            closes = req_tlast || (group_idx >= LAST_GROUP);

            if (group_idx == '0) begin
               head_bits         = seq[11:6];
               item.coded_bits   = conv_run(seq, 6, 2, rate_sel, cnt);
               item.out_position = coded_pos(6, rate_sel);
            end else begin
               item.coded_bits   = conv_run(seq, 0, GROUP_BITS, rate_sel, cnt);
               item.out_position = coded_pos(int'(group_idx) * GROUP_BITS, rate_sel);
            end
            item.coded_count = cnt;
            item.last_result = 1'b0;
            coded_q.push_back(item);

            recent_bits = seq[13:8];
            scr_state   = lfsr;
            group_idx   = group_idx + 1'b1;

            // Tail: windows wrap from the block's end into its first six bits
            if (closes) begin
               seq               = {2'b0, head_bits, recent_bits};
               item.coded_bits   = conv_run(seq, 0, TAIL_BITS, rate_sel, cnt);
               item.coded_count  = cnt;
               item.out_position = '0;
               item.last_result  = 1'b1;
               coded_q.push_back(item);
               clear_block_state();
            end
         end

         // Register write lands after this edge's group
         if (csr_wr_en)
            rate_sel = csr_wr_data;
      end
      outstanding     <= coded_q.size();
      fail_count      <= errors;
      results_checked <= n_checked;
   end

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Stimulus for the scrambled tail-biting encoder: directed blocks at both
// rates and random blocks with random gaps and result stalls. The checker
// beside the block does the scoring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import stce_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_GROUPS   = 800;
   localparam int SETTLE_CYCLES   = 16;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   int fail_count;
   int outstanding;
   int results_checked;
   int groups_sent = 0;
   int blocks_sent = 0;
   int idle_cycles = 0;
   bit steady      = 1'b0;   // no gaps and no stalls while set

   scramble_tailbiting_conv_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stce_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side stalls in about 16 percent of cycles unless steady is set
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 16);
   end

   // Watchdog: too long without any transaction ends the run
   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[%0t] no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // One group transaction, with a random gap ahead of it unless steady is set
   task automatic send_group(input logic [7:0] bits, input logic closes);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      req_tlast  <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      groups_sent++;
      if (closes)
         blocks_sent++;
   endtask

   // Stop sending and wait for every predicted result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_rate(input logic rate);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rate;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Single-group blocks at both extremes, then two- and three-group blocks
   task automatic directed_blocks();
      send_group(8'h00, 1'b1);
      send_group(8'hff, 1'b1);
      send_group(8'h00, 1'b0);
      send_group(8'hff, 1'b1);
      send_group(8'ha5, 1'b0);
      send_group(8'h5a, 1'b0);
      send_group(8'h81, 1'b1);
   endtask

   initial begin : stimulus
      int n_groups;
      int mid_at;
      int rnd_groups;
      int g;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part
      write_rate(RATE_2_5);
      directed_blocks();
      drain_results();
      write_rate(RATE_1_2);
      directed_blocks();

      // Rate changes inside one open block
      drain_results();
      write_rate(RATE_2_5);
      send_group(8'h3c, 1'b0);
      drain_results();
      write_rate(RATE_1_2);
      send_group(8'hc3, 1'b0);
      drain_results();
      write_rate(RATE_2_5);
      send_group(8'h96, 1'b1);

      // Random blocks, mostly short, with a stretch free of gaps and stalls
      rnd_groups = 0;
      while (rnd_groups < RANDOM_GROUPS) begin
         if ($urandom_range(0, 2) == 0) begin
            drain_results();
            write_rate(1'($urandom_range(0, 1)));
         end
         n_groups = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64)
                                                : $urandom_range(1, 8);
         mid_at   = (n_groups > 1 && $urandom_range(0, 9) == 0)
                    ? $urandom_range(1, n_groups - 1) : 0;
         for (g = 0; g < n_groups; g++) begin
            if (g != 0 && g == mid_at) begin
               drain_results();
               write_rate(1'($urandom_range(0, 1)));
            end
            steady <= (rnd_groups >= 300 && rnd_groups < 450);
            send_group(8'($urandom_range(0, 255)), g == n_groups - 1);
            rnd_groups++;
         end
      end
      steady <= 1'b0;

      // A last short block after a fresh rate write
      drain_results();
      write_rate(1'($urandom_range(0, 1)));
      send_group(8'h00, 1'b0);
      send_group(8'hff, 1'b1);

      // Drain with the result side always ready, then settle
      steady <= 1'b1;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d groups in %0d blocks at both rates, with rate changes",
               groups_sent, blocks_sent);
      $display("inside open blocks and random gaps and stalls; %0d %s",
               results_checked, "results compared");
      if (fail_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
